// ===== hw/rtl/arctangent_curve_interpolator_defines.svh =====
// assertion macros for the arctangent curve interpolator
`ifndef ARCTANGENT_CURVE_INTERPOLATOR_DEFINES_SVH
`define ARCTANGENT_CURVE_INTERPOLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition implies expression in the same cycle
`define ACI_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// condition implies expression in the next cycle
`define ACI_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

// condition implies expression a fixed number of cycles later
`define ACI_ASSERT_DELAY(label, clk, rst, cond, dly, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##dly (expr)) \
      else $error(msg);

`else

`define ACI_ASSERT_IMPLY(label, clk, rst, cond, expr, msg)
`define ACI_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`define ACI_ASSERT_DELAY(label, clk, rst, cond, dly, expr, msg)

`endif

`endif

// ===== hw/rtl/aci_pkg.sv =====
// shared types, constants and arithmetic helpers of the arctangent curve interpolator
package aci_pkg;

   // configuration of the arctangent unit
   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 16;

   // field widths
   localparam int DATA_W    = 32;
   localparam int SEV_W     = 24;
   localparam int CSR_IDX_W = 3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_POS   = 3'd0,
      REG_START_VALUE = 3'd1,
      REG_END_POS     = 3'd2,
      REG_END_VALUE   = 3'd3,
      REG_SEVERITY    = 3'd4
   } csr_reg_type;

   localparam logic [SEV_W-1:0] SEV_RESET   = 24'd131072;
   localparam logic [SEV_W-1:0] SEV_LOW_MAX = 24'd65;

   // q16.16 product renormalization and the 2.0 gain of the slope numerator
   localparam int PROD_SHIFT       = 16;
   localparam int SLOPE_GAIN_SHIFT = 17;

   // cordic datapath: x/y carry the q16.16 argument scaled to q20.30
   localparam int CW             = 50;
   localparam int ZW             = 33;
   localparam int CORDIC_Y_SHIFT = 14;
   localparam int ANGLE_SHIFT    = 30 - FRAC_BITS;
   localparam int STAGE_IDX_W    = $clog2(CORDIC_STAGES);
   localparam int ATAN_IDX_W     = 5;
   localparam logic signed [CW-1:0] CORDIC_X0 = CW'(64'd1 << 30);

   // cycles from the accepting edge to the edge that samples the strobe
   localparam int ITEM_LATENCY = CORDIC_STAGES + 6;

   // bit-serial divider
   localparam int DIV_NUM_W = 33 + FRAC_BITS;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // outstanding calibration tokens in the cordic chain
   localparam int CAL_CNT_W = $clog2(ITEM_LATENCY + 1);

   // atan(2^-i) in q2.30
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
      32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
      32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
      32'd32,        32'd16,        32'd8,         32'd4,         32'd2,
      32'd1,         32'd0
   };

   localparam logic signed [63:0] INT32_MAX_W = 64'sd2147483647;
   localparam logic signed [63:0] INT32_MIN_W = -64'sd2147483648;

   // token moving down the cordic chain
   typedef struct packed {
      logic                 valid;
      logic                 cal;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_token_type;

   // derived curve terms handed from setup to the datapath
   typedef struct packed {
      logic signed [DATA_W-1:0] slope;
      logic signed [DATA_W-1:0] intercept;
      logic signed [DATA_W-1:0] scale;
      logic signed [DATA_W-1:0] offset;
      logic [SEV_W-1:0]         severity;
      logic                     sev_low;
   } derived_type;

   // calibration angle returned from the end of the chain
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] angle;
   } cal_return_type;

   // divider result
   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_result_type;

   // saturate to 32 bit signed
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > INT32_MAX_W) begin
         r = 32'sh7fffffff;
      end else if (v < INT32_MIN_W) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   // shift right rounding half away from zero, s at least one
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
      logic signed [63:0] half;
      logic signed [63:0] r;
      half = 64'sd1 <<< (s - 1);
      if (v >= 0) begin
         r = (v + half) >>> s;
      end else begin
         r = -((-v + half) >>> s);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/aci_cordic_cell.sv =====
// one vectoring cordic iteration with its pipeline register
module aci_cordic_cell import aci_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [STAGE_IDX_W-1:0] stage_idx,
   input  cordic_token_type       cell_in,
   output cordic_token_type       cell_out
);

   cordic_token_type     token_ff;
   cordic_token_type     token_in;
   logic signed [CW-1:0] x;
   logic signed [CW-1:0] y;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [ZW-1:0] z;
   logic signed [ZW-1:0] step;

   // rotate toward the x axis by atan(2^-i)
   always_comb begin
      x    = cell_in.x;
      y    = cell_in.y;
      z    = cell_in.z;
      xs   = x >>> stage_idx;
      ys   = y >>> stage_idx;
      step = signed'(ZW'(ATAN_TAB[ATAN_IDX_W'(stage_idx)]));
      token_in = cell_in;
      if (y >= 0) begin
         token_in.x = x + ys;
         token_in.y = y - xs;
         token_in.z = z + step;
      end else begin
         token_in.x = x - ys;
         token_in.y = y + xs;
         token_in.z = z - step;
      end
   end

   // stage register, only the valid bit is cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in.valid;
      end
      token_ff.cal <= token_in.cal;
      token_ff.x   <= token_in.x;
      token_ff.y   <= token_in.y;
      token_ff.z   <= token_in.z;
   end

   assign cell_out = token_ff;

endmodule

// ===== hw/rtl/aci_divider.sv =====
// bit-serial restoring divider on unsigned magnitudes
module aci_divider import aci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 div_start,
   input  logic [DIV_NUM_W-1:0] div_num,
   input  logic [DIV_DEN_W-1:0] div_den,
   output div_result_type       div_res
);

   logic                 running_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;
   logic [DIV_DEN_W-1:0] rem_in;

   // one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
   end

   // control and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff <= running_ff && !div_start && (cnt_ff == DIV_CNT_W'(1));
         if (div_start) begin
            running_ff <= 1'b1;
            cnt_ff     <= DIV_CNT_W'(DIV_NUM_W);
            rem_ff     <= '0;
            quo_ff     <= div_num;
            den_ff     <= div_den;
         end else if (running_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               running_ff <= 1'b0;
            end
         end
      end
   end

   assign div_res.done = done_ff;
   assign div_res.quot = quo_ff;

endmodule

// ===== hw/rtl/aci_setup.sv =====
// configuration registers and the sequencer that derives the curve terms
module aci_setup import aci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   input  cal_return_type       cal_ret,
   output logic                 setup_busy,
   output logic                 cal_issue,
   output derived_type          derived
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SLOPE,
      S_MUL,
      S_ICPT,
      S_CAL_WAIT,
      S_SCALE
   } state_type;

   state_type                state_ff;
   logic signed [DATA_W-1:0] start_pos_ff;
   logic signed [DATA_W-1:0] start_value_ff;
   logic signed [DATA_W-1:0] end_pos_ff;
   logic signed [DATA_W-1:0] end_value_ff;
   logic [SEV_W-1:0]         severity_ff;
   logic signed [DATA_W-1:0] slope_ff;
   logic signed [DATA_W-1:0] intercept_ff;
   logic signed [DATA_W-1:0] scale_ff;
   logic signed [DATA_W-1:0] offset_ff;
   logic signed [63:0]       prod_ff;
   logic signed [DATA_W-1:0] angle_ff;
   logic                     div_neg_ff;
   logic [CAL_CNT_W-1:0]     cal_cnt_ff;
   logic [CAL_CNT_W-1:0]     cal_cnt_in;

   logic signed [32:0]       run;
   logic signed [32:0]       rise;
   logic signed [32:0]       vsum;
   logic signed [32:0]       denom;
   logic [32:0]              run_mag;
   logic [32:0]              rise_mag;
   logic [32:0]              denom_mag;
   logic signed [DATA_W-1:0] offset_calc;
   logic signed [DATA_W-1:0] icpt_calc;
   logic signed [DIV_NUM_W:0] quot_signed;
   logic signed [DATA_W-1:0] quot_sat;
   logic                     div_start;
   logic [DIV_NUM_W-1:0]     div_num;
   logic [DIV_DEN_W-1:0]     div_den;
   div_result_type           div_res;
   logic                     cal_ready;
   logic                     csr_hit;

   aci_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (div_den),
      .div_res   (div_res)
   );

   // differences, magnitudes and the simple terms
   always_comb begin
      run       = 33'(end_pos_ff) - 33'(start_pos_ff);
      rise      = 33'(end_value_ff) - 33'(start_value_ff);
      vsum      = 33'(start_value_ff) + 33'(end_value_ff);
      denom     = signed'({angle_ff, 1'b0});
      run_mag   = run[32] ? 33'(-run) : 33'(run);
      rise_mag  = rise[32] ? 33'(-rise) : 33'(rise);
      denom_mag = denom[32] ? 33'(-denom) : 33'(denom);
      offset_calc = vsum[32] ? 32'((vsum + 33'sd1) >>> 1) : 32'(vsum >>> 1);
      icpt_calc = sat32(-round_shift(prod_ff, PROD_SHIFT) - signed'(64'(severity_ff)));
      quot_signed = div_neg_ff ? -signed'({1'b0, div_res.quot})
                               : signed'({1'b0, div_res.quot});
      quot_sat  = sat32(64'(quot_signed));
      cal_ready = (cal_cnt_ff == '0);
      csr_hit   = csr_we && (csr_index <= REG_SEVERITY);
   end

   // divider launch
   always_comb begin
      div_start = 1'b0;
      div_num   = DIV_NUM_W'(severity_ff) << SLOPE_GAIN_SHIFT;
      div_den   = run_mag;
      case (state_ff)
         S_START: begin
            div_start = (run != 33'sd0);
         end
         S_CAL_WAIT: begin
            div_num   = DIV_NUM_W'(rise_mag) << FRAC_BITS;
            div_den   = denom_mag;
            div_start = cal_ready && (denom != 33'sd0);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // calibration token bookkeeping, tokens return in order
   always_comb begin
      cal_issue  = (state_ff == S_START);
      cal_cnt_in = cal_cnt_ff + CAL_CNT_W'(cal_issue) - CAL_CNT_W'(cal_ret.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_cnt_ff <= '0;
      end else begin
         cal_cnt_ff <= cal_cnt_in;
      end
      if (cal_ret.valid) begin
         angle_ff <= cal_ret.angle;
      end
   end

   // register writes and the derivation sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         start_pos_ff   <= '0;
         start_value_ff <= '0;
         end_pos_ff     <= '0;
         end_value_ff   <= '0;
         severity_ff    <= SEV_RESET;
         slope_ff       <= '0;
         intercept_ff   <= -signed'(32'(SEV_RESET));
         scale_ff       <= '0;
         offset_ff      <= '0;
         div_neg_ff     <= 1'b0;
      end else begin
         // a register write restarts the derivation
         if (csr_hit) begin
            state_ff <= S_START;
         end else begin
            case (state_ff)
               S_START: begin
                  if (run == 33'sd0) begin
                     slope_ff <= '0;
                     state_ff <= S_MUL;
                  end else begin
                     div_neg_ff <= run[32];
                     state_ff   <= S_SLOPE;
                  end
               end
               S_SLOPE: begin
                  if (div_res.done) begin
                     slope_ff <= quot_sat;
                     state_ff <= S_MUL;
                  end
               end
               S_MUL: begin
                  prod_ff  <= start_pos_ff * slope_ff;
                  state_ff <= S_ICPT;
               end
               S_ICPT: begin
                  intercept_ff <= icpt_calc;
                  offset_ff    <= offset_calc;
                  state_ff     <= S_CAL_WAIT;
               end
               S_CAL_WAIT: begin
                  if (cal_ready) begin
                     if (denom == 33'sd0) begin
                        scale_ff <= '0;
                        state_ff <= S_IDLE;
                     end else begin
                        div_neg_ff <= rise[32] ^ denom[32];
                        state_ff   <= S_SCALE;
                     end
                  end
               end
               S_SCALE: begin
                  if (div_res.done) begin
                     scale_ff <= quot_sat;
                     state_ff <= S_IDLE;
                  end
               end
               default: begin
                  state_ff <= S_IDLE;
               end
            endcase
         end

         if (csr_we) begin
            case (csr_index)
               REG_START_POS:   start_pos_ff   <= csr_wdata;
               REG_START_VALUE: start_value_ff <= csr_wdata;
               REG_END_POS:     end_pos_ff     <= csr_wdata;
               REG_END_VALUE:   end_value_ff   <= csr_wdata;
               REG_SEVERITY:    severity_ff    <= csr_wdata[SEV_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign setup_busy         = (state_ff != S_IDLE);
   assign derived.slope      = slope_ff;
   assign derived.intercept  = intercept_ff;
   assign derived.scale      = scale_ff;
   assign derived.offset     = offset_ff;
   assign derived.severity   = severity_ff;
   assign derived.sev_low    = (severity_ff <= SEV_LOW_MAX);

endmodule

// ===== hw/rtl/arctangent_curve_interpolator.sv =====
// top level of the arctangent s-curve interpolator
//
// Evaluates value = scale * atan(slope * position + intercept) + offset, an
// s-curve through a start and an end point, all values signed q16.16.
// Input: drive req_position with start high; the word is taken at a rising
// edge where start is high and busy is low; one word per cycle while busy is low.
// Output: rsp_strobe is high for one cycle with rsp_curve_value and
// rsp_severity_low; the receiver cannot stall, so results are never held.
// Pipeline: from the accepting edge the word passes, in order, the input
// register, slope multiply, argument add, one register per cordic cell, angle
// rounding, scale multiply and output registers.
// Configuration: csr_we/csr_index/csr_wdata write a register; the user must
// write only while no word is in flight, which the block does not enforce.
// Each write reruns the term derivation and holds busy high while the shared
// bit-serial divider derives the slope, then the scale; the severity angle
// crosses the cordic chain meanwhile. With a zero run there is no slope
// division, and the scale division waits for the severity angle to return.
// Reset: synchronous; registers return to their defaults and the derived
// terms to their default values at once, so busy is low right after reset.
`include "arctangent_curve_interpolator_defines.svh"

module arctangent_curve_interpolator import aci_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_position,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_curve_value,
   output logic                     rsp_severity_low,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   derived_type              derived;
   cal_return_type           cal_ret;
   logic                     setup_busy;
   logic                     cal_issue;
   logic                     accept;

   logic signed [DATA_W-1:0] slope;
   logic signed [DATA_W-1:0] intercept;
   logic signed [DATA_W-1:0] scale;
   logic signed [DATA_W-1:0] offset;

   logic                     s0_valid_ff;
   logic signed [DATA_W-1:0] s0_pos_ff;
   logic                     s1_valid_ff;
   logic signed [63:0]       s1_prod_ff;
   logic signed [63:0]       s1_prod_in;
   logic                     s2_valid_ff;
   logic signed [DATA_W-1:0] s2_arg_ff;
   logic signed [DATA_W-1:0] s2_arg_in;
   logic                     s3_valid_ff;
   logic                     s3_cal_ff;
   logic signed [DATA_W-1:0] s3_angle_ff;
   logic signed [DATA_W-1:0] s3_angle_in;
   logic                     s4_valid_ff;
   logic                     s4_valid_in;
   logic signed [63:0]       s4_prod_ff;
   logic signed [63:0]       s4_prod_in;
   logic                     s4_low_ff;
   logic                     rsp_strobe_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_value_in;
   logic                     rsp_low_ff;

   logic signed [DATA_W-1:0] head_arg;
   logic signed [ZW-1:0]     tail_z;
   cordic_token_type         chain [CORDIC_STAGES+1];

   aci_setup u_setup (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cal_ret    (cal_ret),
      .setup_busy (setup_busy),
      .cal_issue  (cal_issue),
      .derived    (derived)
   );

   assign busy      = setup_busy;
   assign accept    = start && !setup_busy;
   assign slope     = derived.slope;
   assign intercept = derived.intercept;
   assign scale     = derived.scale;
   assign offset    = derived.offset;

   // slope multiply and argument
   always_comb begin
      s1_prod_in = s0_pos_ff * slope;
      s2_arg_in  = sat32(round_shift(s1_prod_ff, PROD_SHIFT) + 64'(intercept));
   end

   // chain head: a word, or the severity angle during derivation
   always_comb begin
      head_arg       = cal_issue ? signed'(32'(derived.severity)) : s2_arg_ff;
      chain[0].valid = s2_valid_ff || cal_issue;
      chain[0].cal   = cal_issue;
      chain[0].x     = CORDIC_X0;
      chain[0].y     = CW'(head_arg) <<< CORDIC_Y_SHIFT;
      chain[0].z     = '0;
   end

   // row of cordic cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      aci_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STAGE_IDX_W'(i)),
         .cell_in   (chain[i]),
         .cell_out  (chain[i+1])
      );
   end

   // angle rounding, scale multiply and output value
   always_comb begin
      tail_z       = chain[CORDIC_STAGES].z;
      s3_angle_in  = 32'(round_shift(64'(tail_z), ANGLE_SHIFT));
      s4_valid_in  = s3_valid_ff && !s3_cal_ff;
      s4_prod_in   = scale * s3_angle_ff;
      rsp_value_in = sat32(round_shift(s4_prod_ff, FRAC_BITS) + 64'(offset));
   end

   assign cal_ret.valid = s3_valid_ff && s3_cal_ff;
   assign cal_ret.angle = s3_angle_ff;

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s0_valid_ff   <= accept;
         s1_valid_ff   <= s0_valid_ff;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= chain[CORDIC_STAGES].valid;
         s4_valid_ff   <= s4_valid_in;
         rsp_strobe_ff <= s4_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s0_pos_ff    <= req_position;
      s1_prod_ff   <= s1_prod_in;
      s2_arg_ff    <= s2_arg_in;
      s3_cal_ff    <= chain[CORDIC_STAGES].cal;
      s3_angle_ff  <= s3_angle_in;
      s4_prod_ff   <= s4_prod_in;
      s4_low_ff    <= derived.sev_low;
      rsp_value_ff <= rsp_value_in;
      rsp_low_ff   <= s4_low_ff;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_curve_value  = rsp_value_ff;
   assign rsp_severity_low = rsp_low_ff;

   // every accepted word gives a result after the fixed latency
   `ACI_ASSERT_DELAY(a_item_latency, clock, reset, start && !busy, ITEM_LATENCY, rsp_strobe, "accepted word gave no result")
   // no result without an accepted word
   `ACI_ASSERT_IMPLY(a_no_extra_result, clock, reset, rsp_strobe, $past(start && !busy, ITEM_LATENCY), "result without accepted word")
   // a register write blocks input until the terms are derived again
   `ACI_ASSERT_NEXT(a_cfg_busy, clock, reset, csr_we && csr_index <= REG_SEVERITY, busy, "write did not start derivation")

endmodule
